FILE: hw/rtl/ims_pkg.sv
// shared types, widths and register codes for the six-axis imu smoother
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ims_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int NUM_CHAN       = 6;
   localparam int NUM_AXIS       = 3;
   localparam int DEB_W          = SAMPLE_W + 1;
   localparam int LIMIT_W        = 15;
   localparam int CSR_INDEX_W    = 3;
   localparam int WINDOW_DEFAULT = 10;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET = 15'd800;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GYRO_OFFSET_X   = 3'd0,
      CSR_GYRO_OFFSET_Y   = 3'd1,
      CSR_GYRO_OFFSET_Z   = 3'd2,
      CSR_GYRO_STEP_LIMIT = 3'd3
   } csr_index_type;

   typedef logic signed [SAMPLE_W-1:0] s16_type;
   typedef logic signed [DEB_W-1:0]    deb_type;

   // channel order: accel x, y, z, then gyro x, y, z
   typedef s16_type [NUM_CHAN-1:0] row_type;
   typedef s16_type [NUM_AXIS-1:0] axis_type;

   typedef struct packed {
      row_type                raw;
      deb_type [NUM_AXIS-1:0] deb;
   } q_entry_type;

   typedef struct packed {
      axis_type             offset;
      logic [LIMIT_W-1:0]   step_limit;
   } cfg_type;

   typedef struct packed {
      row_type  mean;
      axis_type smooth;
   } result_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_UPDATE,
      BK_MUL,
      BK_FIN,
      BK_DONE
   } back_state_type;

endpackage

FILE: hw/rtl/ims_csr.sv
// configuration registers: gyro offsets and gyro step limit
// depends on ims_pkg
`timescale 1ns / 1ps

module ims_csr import ims_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SAMPLE_W-1:0]    csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GYRO_OFFSET_X:   cfg_in.offset[0]  = csr_wdata;
            CSR_GYRO_OFFSET_Y:   cfg_in.offset[1]  = csr_wdata;
            CSR_GYRO_OFFSET_Z:   cfg_in.offset[2]  = csr_wdata;
            CSR_GYRO_STEP_LIMIT: cfg_in.step_limit = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset     <= '0;
         cfg_ff.step_limit <= STEP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/ims_front.sv
// front end: accepts samples, removes gyro bias, queues them for the back end
// depends on ims_pkg
`timescale 1ns / 1ps

module ims_front import ims_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  row_type     req_row,
   input  cfg_type     cfg,
   output logic        q_valid,
   input  logic        q_ready,
   output q_entry_type q_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   q_entry_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   q_entry_type      new_entry;
   logic             push;
   logic             pop;

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      new_entry.raw = req_row;
      for (int a = 0; a < NUM_AXIS; a++) begin
         new_entry.deb[a] = {req_row[NUM_AXIS+a][SAMPLE_W-1], req_row[NUM_AXIS+a]}
                          - {cfg.offset[a][SAMPLE_W-1], cfg.offset[a]};
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

FILE: hw/rtl/ims_back.sv
// back end: window memory with running sums, shared reciprocal divider,
// slew-limited gyro filter and output register; depends on ims_pkg
`timescale 1ns / 1ps

module ims_back import ims_pkg::*; #(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  q_entry_type q_entry,
   input  cfg_type     cfg,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output result_type  rsp_data
);

   localparam int LOG_W  = $clog2(WINDOW);
   localparam int SUM_W  = SAMPLE_W + LOG_W;
   localparam int DIV_S  = SUM_W + LOG_W;
   localparam int MULT_W = SUM_W + 1;
   localparam int PROD_W = SUM_W + MULT_W;
   localparam int Q_W    = SAMPLE_W + 1;
   localparam int CH_W   = $clog2(NUM_CHAN);
   localparam int AX_W   = $clog2(NUM_AXIS);
   localparam longint unsigned DIV_M_L =
      ((longint'(1) << DIV_S) + longint'(WINDOW) - 1) / longint'(WINDOW);
   localparam logic [MULT_W-1:0] DIV_M      = MULT_W'(DIV_M_L);
   localparam logic [CH_W-1:0]   FIRST_GYRO = CH_W'(NUM_AXIS);
   localparam logic [CH_W-1:0]   LAST_CHAN  = CH_W'(NUM_CHAN - 1);

   function automatic s16_type sat16(input logic signed [17:0] v);
      if (v > 18'sd32767) begin
         return 16'sh7fff;
      end else if (v < -18'sd32768) begin
         return 16'sh8000;
      end else begin
         return v[15:0];
      end
   endfunction

   // window memory
   row_type          win_mem [WINDOW];
   row_type          rd_data_ff;
   logic             mem_we;
   logic [WINDOW-1:0] row_valid_ff, row_valid_in;
   row_type          old_row;

   back_state_type   state_ff, state_in;
   logic [CH_W-1:0]  ch_ff, ch_in;
   logic [LOG_W-1:0] slot_ff, slot_in;
   logic [SUM_W-1:0] sum_ff [NUM_CHAN];
   logic [SUM_W-1:0] sum_in [NUM_CHAN];
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic             neg_ff, neg_in;
   deb_type          filt_ff, filt_in;
   axis_type         smooth_ff, smooth_in;
   row_type          mean_ff, mean_in;
   result_type       res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [AX_W-1:0]  axis;
   logic [SUM_W-1:0] sum_sel;
   logic [SUM_W-1:0] mag;
   s16_type          prev;
   logic [18:0]      filt_acc;
   logic [18:0]      filt_adj;
   logic [Q_W-1:0]   quo;
   logic [Q_W-1:0]   mean_s;
   logic signed [17:0] gyro_diff;
   logic signed [17:0] lo_bound;
   logic signed [17:0] hi_bound;
   logic signed [17:0] filt_ext;
   logic signed [17:0] clamped;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = res_ff;
   assign old_row   = row_valid_ff[slot_ff] ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      rd_data_ff <= win_mem[slot_ff];
      if (mem_we) begin
         win_mem[slot_ff] <= q_entry.raw;
      end
   end

   // per-channel datapath terms
   always_comb begin
      axis     = AX_W'(ch_ff - FIRST_GYRO);
      sum_sel  = sum_ff[ch_ff];
      mag      = sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;
      prev     = smooth_ff[axis];
      filt_acc = ({{3{prev[SAMPLE_W-1]}}, prev} << 1) + {{3{prev[SAMPLE_W-1]}}, prev}
               + {{2{q_entry.deb[axis][DEB_W-1]}}, q_entry.deb[axis]};
      filt_adj = filt_acc + (filt_acc[18] ? 19'd3 : 19'd0);
      quo      = prod_ff[DIV_S +: Q_W];
      mean_s   = neg_ff ? (~quo + 1'b1) : quo;
      gyro_diff = {mean_s[Q_W-1], mean_s}
                - {{2{cfg.offset[axis][SAMPLE_W-1]}}, cfg.offset[axis]};
      lo_bound = {{2{prev[SAMPLE_W-1]}}, prev} - {3'b000, cfg.step_limit};
      hi_bound = {{2{prev[SAMPLE_W-1]}}, prev} + {3'b000, cfg.step_limit};
      filt_ext = {filt_ff[DEB_W-1], filt_ff};
      if (filt_ext < lo_bound) begin
         clamped = lo_bound;
      end else if (filt_ext > hi_bound) begin
         clamped = hi_bound;
      end else begin
         clamped = filt_ext;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      slot_in      = slot_ff;
      row_valid_in = row_valid_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      filt_in      = filt_ff;
      smooth_in    = smooth_ff;
      mean_in      = mean_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      q_ready      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               state_in = BK_UPDATE;
            end
         end
         BK_UPDATE: begin
            // running sums: add the new sample, drop the one it replaces
            mem_we                = 1'b1;
            row_valid_in[slot_ff] = 1'b1;
            for (int c = 0; c < NUM_CHAN; c++) begin
               sum_in[c] = sum_ff[c]
                         + {{(SUM_W-SAMPLE_W){q_entry.raw[c][SAMPLE_W-1]}}, q_entry.raw[c]}
                         - {{(SUM_W-SAMPLE_W){old_row[c][SAMPLE_W-1]}}, old_row[c]};
            end
            slot_in  = (slot_ff == LOG_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            ch_in    = '0;
            state_in = BK_MUL;
         end
         BK_MUL: begin
            neg_in  = sum_sel[SUM_W-1];
            prod_in = PROD_W'(mag) * PROD_W'(DIV_M);
            if (ch_ff >= FIRST_GYRO) begin
               filt_in = filt_adj[18:2];
            end
            state_in = BK_FIN;
         end
         BK_FIN: begin
            if (ch_ff >= FIRST_GYRO) begin
               mean_in[ch_ff]  = sat16(gyro_diff);
               smooth_in[axis] = sat16(clamped);
            end else begin
               mean_in[ch_ff] = mean_s[SAMPLE_W-1:0];
            end
            if (ch_ff == LAST_CHAN) begin
               state_in = BK_DONE;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = BK_MUL;
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               q_ready       = 1'b1;
               rsp_valid_in  = 1'b1;
               res_in.mean   = mean_ff;
               res_in.smooth = smooth_ff;
               state_in      = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         ch_ff        <= '0;
         slot_ff      <= '0;
         row_valid_ff <= '0;
         sum_ff       <= '{default: '0};
         smooth_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         slot_ff      <= slot_in;
         row_valid_ff <= row_valid_in;
         sum_ff       <= sum_in;
         smooth_ff    <= smooth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      filt_ff <= filt_in;
      mean_ff <= mean_in;
      res_ff  <= res_in;
   end

endmodule

FILE: hw/rtl/imu_six_axis_smoother.sv
// top level of the six-axis imu smoother: config registers, front end, back end
// depends on ims_pkg, ims_csr, ims_front, ims_back
`timescale 1ns / 1ps

// Usage
//   req_*  : one six-axis sample per request (valid/ready), signed 16 bit
//   rsp_*  : one result per request: six window means and three smoothed
//            gyro rates, signed 16 bit, held in an output register
//   csr_*  : register writes (index, data), always ready; write only while idle
//   The back end works on one sample at a time: each of the six channel means
//   goes in turn through the one shared reciprocal multiplier, in a multiply
//   step and then a finish step, before the result is registered.
//   A two-entry queue sits between the front and back ends, so a new request
//   is taken while the back end is busy or a result waits to be taken.
//   A stalled result holds the back end in its last step; the queue then
//   fills and req_ready drops.
//   Reset clears the window (per-row valid bits), running sums, smoothed
//   rates and write slot, and loads offsets 0 and step limit 800. No
//   clearing pass is needed; requests are taken right after reset.
module imu_six_axis_smoother import ims_pkg::*; #(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     req_accel_x,
   input  logic signed [15:0]     req_accel_y,
   input  logic signed [15:0]     req_accel_z,
   input  logic signed [15:0]     req_gyro_x,
   input  logic signed [15:0]     req_gyro_y,
   input  logic signed [15:0]     req_gyro_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [15:0]     rsp_mean_accel_x,
   output logic signed [15:0]     rsp_mean_accel_y,
   output logic signed [15:0]     rsp_mean_accel_z,
   output logic signed [15:0]     rsp_mean_gyro_x,
   output logic signed [15:0]     rsp_mean_gyro_y,
   output logic signed [15:0]     rsp_mean_gyro_z,
   output logic signed [15:0]     rsp_smooth_gyro_x,
   output logic signed [15:0]     rsp_smooth_gyro_y,
   output logic signed [15:0]     rsp_smooth_gyro_z,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wdata
);

   cfg_type     cfg;
   row_type     req_row;
   logic        q_valid;
   logic        q_ready;
   q_entry_type q_entry;
   result_type  rsp_data;

   always_comb begin
      req_row[0] = req_accel_x;
      req_row[1] = req_accel_y;
      req_row[2] = req_accel_z;
      req_row[3] = req_gyro_x;
      req_row[4] = req_gyro_y;
      req_row[5] = req_gyro_z;
   end

   assign rsp_mean_accel_x  = rsp_data.mean[0];
   assign rsp_mean_accel_y  = rsp_data.mean[1];
   assign rsp_mean_accel_z  = rsp_data.mean[2];
   assign rsp_mean_gyro_x   = rsp_data.mean[3];
   assign rsp_mean_gyro_y   = rsp_data.mean[4];
   assign rsp_mean_gyro_z   = rsp_data.mean[5];
   assign rsp_smooth_gyro_x = rsp_data.smooth[0];
   assign rsp_smooth_gyro_y = rsp_data.smooth[1];
   assign rsp_smooth_gyro_z = rsp_data.smooth[2];

   ims_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ims_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_row   (req_row),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_entry   (q_entry)
   );

   ims_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_entry   (q_entry),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // a finished request is retired from the queue only into a free output slot
   a_pop_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |-> (!rsp_valid || rsp_ready))
      else $error("queue popped while output register still occupied");

   // every retired request shows up as a result in the next cycle
   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |=> rsp_valid)
      else $error("retired request produced no result");

   // a result appears only right after a request was retired
   a_result_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_valid && q_ready))
      else $error("result appeared without a retired request");
`endif

endmodule
